// ----- hw/rtl/cnfd_pkg.sv -----
// Shared types, constants and helpers for the clip / normalize / feedback delay block.
// No dependencies; imported by clip_normalize_feedback_delay_top.
package cnfd_pkg;

  // Delay store depth, a power of two so that address arithmetic wraps naturally.
  localparam int DELAY_DEPTH = 65536;
  localparam int DLY_AW      = $clog2(DELAY_DEPTH);

  // Width of the restoring divider quotient; the quotient never exceeds 32768.
  localparam int DIV_STEPS   = 16;
  localparam int DIV_CW      = $clog2(DIV_STEPS);

  // Feedback rounding: add half an LSB of the Q2.14 product before the floor shift.
  localparam logic signed [31:0] FB_ROUND = 32'sd8192;

  // Reset values of the configuration registers.
  localparam logic [14:0] CLIP_THRESHOLD_RST = 15'd32767;
  localparam logic [14:0] DELAY_SAMPLES_RST  = 15'd22050;
  localparam logic [14:0] FEEDBACK_GAIN_RST  = 15'd8192;

  typedef enum logic [1:0] {
    REG_CLIP_THRESHOLD = 2'd0,
    REG_DELAY_SAMPLES  = 2'd1,
    REG_FEEDBACK_GAIN  = 2'd2
  } cnfd_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_MUL,
    ST_WRITE,
    ST_OUT
  } cnfd_state_t;

  // Saturate a 19-bit signed value to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/clip_normalize_feedback_delay_top.sv -----
// Hard-clip distortion with normalization and a feedback delay line.
// Depends on cnfd_pkg (state type, register codes, depth, saturation helper).
//
// Flow: an accepted item passes READ, DIV (the 16-step restoring divider, one
//   quotient bit per cycle), MUL, WRITE and OUT, which loads the result and raises
//   out_valid. in_stall is high outside IDLE, and OUT waits out a stalled result.
// Reset (rst_n, synchronous, active low) clears control state and loads the
//   register defaults; the delay store is not swept, a fill mark makes unwritten
//   entries read as zero, so the block is ready right after reset.
module clip_normalize_feedback_delay_top
  import cnfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  // result item channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes drop.
  // ---------------------------------------------------------------------------
  logic [14:0] clip_threshold_r;
  logic [14:0] delay_samples_r;
  logic [14:0] feedback_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_threshold_r <= CLIP_THRESHOLD_RST;
      delay_samples_r  <= DELAY_SAMPLES_RST;
      feedback_gain_r  <= FEEDBACK_GAIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cnfd_reg_t'(cfg_index))
        REG_CLIP_THRESHOLD: clip_threshold_r <= cfg_data;
        REG_DELAY_SAMPLES:  delay_samples_r  <= cfg_data;
        REG_FEEDBACK_GAIN:  feedback_gain_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> READ -> DIV (16 steps) -> MUL -> WRITE -> OUT -> IDLE
  // ---------------------------------------------------------------------------
  cnfd_state_t state_r, state_nxt;
  logic [DIV_CW-1:0] div_cnt_r;
  logic              out_valid_r;

  logic in_take;    // accept an item
  logic div_init;   // load the divider from the clipped magnitude
  logic mem_re;     // read the delayed entry
  logic div_step;   // one quotient bit
  logic mul_en;     // register the feedback product
  logic mem_we;     // store the new delay entry, advance the write position
  logic out_load;   // move the result into the output register

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_DIV;
      ST_DIV:   if (div_cnt_r == DIV_CW'(DIV_STEPS - 1)) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    in_take  = 1'b0;
    div_init = 1'b0;
    mem_re   = 1'b0;
    div_step = 1'b0;
    mul_en   = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        in_take  = in_valid;
      end
      ST_READ: begin
        div_init = 1'b1;
        mem_re   = 1'b1;
      end
      ST_DIV:   div_step = 1'b1;
      ST_MUL:   mul_en   = 1'b1;
      ST_WRITE: mem_we   = 1'b1;
      ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      if (div_step) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clip: hold the input sample and the magnitude clipped to the threshold.
  // ---------------------------------------------------------------------------
  logic signed [15:0] x_r;
  logic               neg_r;
  logic [14:0]        mag_r;
  logic [15:0]        in_mag;

  assign in_mag = in_sample[15] ? (~in_sample + 16'd1) : in_sample;

  always_ff @(posedge clk) begin
    if (in_take) begin
      x_r   <= in_sample;
      neg_r <= in_sample[15];
      mag_r <= (in_mag > {1'b0, clip_threshold_r}) ? clip_threshold_r : in_mag[14:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Restoring divider: (mag << 15) / threshold, one quotient bit a cycle.
  // The top part of the dividend (mag >> 1) is already below the threshold, so
  // only the 16 low dividend bits are shifted through the remainder.
  // ---------------------------------------------------------------------------
  logic [14:0] rem_r;
  logic [15:0] divq_r;     // low dividend bits in, quotient bits out
  logic [15:0] trial;
  logic        trial_ge;

  assign trial    = {rem_r, divq_r[15]};
  assign trial_ge = trial >= {1'b0, clip_threshold_r};

  always_ff @(posedge clk) begin
    if (div_init) begin
      rem_r  <= {1'b0, mag_r[14:1]};
      divq_r <= {mag_r[0], 15'd0};
    end else if (div_step) begin
      rem_r  <= trial_ge ? 15'(trial - {1'b0, clip_threshold_r}) : trial[14:0];
      divq_r <= {divq_r[14:0], trial_ge};
    end
  end

  // ---------------------------------------------------------------------------
  // Delay store. Writes run sequentially from address zero, so an entry has
  // been written iff the write pointer has wrapped once or it lies below it.
  // ---------------------------------------------------------------------------
  logic signed [15:0] dly_mem [DELAY_DEPTH];
  logic [DLY_AW-1:0]  wp_r;
  logic               wrapped_r;
  logic [DLY_AW-1:0]  rd_addr;
  logic signed [15:0] mem_q_r;
  logic               rd_ok_r;
  logic signed [15:0] store_val;
  logic signed [15:0] stored_r;

  // Distance modulo depth falls out of the address width.
  assign rd_addr = wp_r - DLY_AW'({{DLY_AW{1'b0}}, delay_samples_r});

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dly_mem[wp_r] <= store_val;
    end
    if (mem_re) begin
      mem_q_r <= dly_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      rd_ok_r   <= 1'b0;
    end else begin
      if (mem_re) begin
        rd_ok_r <= wrapped_r || (rd_addr < wp_r);
      end
      if (mem_we) begin
        wp_r <= wp_r + 1'b1;
        if (wp_r == DLY_AW'(DELAY_DEPTH - 1)) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Feedback: product registered in MUL, rounded and summed in WRITE timing.
  // ---------------------------------------------------------------------------
  logic signed [31:0] prod_r;
  logic signed [15:0] past;
  logic signed [31:0] prod_rnd;
  logic signed [17:0] fbk;
  logic signed [18:0] store_sum;

  assign past = rd_ok_r ? mem_q_r : 16'sd0;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= past * $signed({1'b0, feedback_gain_r});
    end
  end

  assign prod_rnd  = prod_r + FB_ROUND;
  assign fbk       = prod_rnd[31:14];
  assign store_sum = {{3{x_r[15]}}, x_r} + {fbk[17], fbk};
  assign store_val = sat16(store_sum);

  // Hold the stored value from WRITE for the output sum.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stored_r <= store_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: normalized clip plus stored value, saturated, in a holding register.
  // ---------------------------------------------------------------------------
  logic signed [16:0] norm;
  logic signed [18:0] out_sum;
  logic signed [15:0] out_sample_r;

  always_comb begin
    if (clip_threshold_r == 15'd0) begin
      norm = 17'sd0;
    end else if (neg_r) begin
      norm = -$signed({1'b0, divq_r});
    end else if (divq_r[15]) begin
      norm = 17'sd32767;
    end else begin
      norm = $signed({1'b0, divq_r});
    end
  end

  assign out_sum = {{2{norm[16]}}, norm} + {{3{stored_r[15]}}, stored_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= sat16(out_sum);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_stall)
    else $error("block not busy after taking an item");

  a_div_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DIV) |-> (div_cnt_r == '0))
    else $error("divider step count left nonzero outside division");

  a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> (wp_r == DLY_AW'($past(wp_r) + 1'b1)))
    else $error("write position did not advance after a store");

  a_unwritten_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && !wrapped_r && (rd_addr >= wp_r)) |=> !rd_ok_r)
    else $error("unwritten delay entry marked as written");

endmodule

// ----- test/tb_clip_normalize_feedback_delay_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for clip_normalize_feedback_delay_top: a directed table, then
// random phases under varied idling and back-pressure, each result matched to the predictor or a typed value.
// Depends on cnfd_pkg and the block's RTL only.
module tb_clip_normalize_feedback_delay_top;
  import cnfd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 3;
  // Watchdog bound, set with a wide margin over the slowest legal run.
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_SHOWN    = 10;
  // Idle tail run after every owed result has come back.
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 400;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_ROWS     = 37;
  // Index past the end of the register list; the block must ignore it.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One line of the directed table: a register write or one sample item.
  // For items, 'typed' selects the hand-written result over the predictor's.
  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         idx;
    logic [14:0]        value;
    logic signed [15:0] sample;
    logic               typed;
    logic signed [15:0] want;
  } stim_row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample  = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index  = '0;
  logic [14:0]        cfg_data   = '0;

  // Predictor state: its own echo line, write pointer and register shadows.
  logic signed [15:0] echo_line [DELAY_DEPTH];
  int unsigned        echo_wr;
  logic [14:0]        thr_cfg;
  logic [14:0]        delay_cfg;
  logic [14:0]        gain_cfg;

  // Output samples still owed by the block, oldest first.
  logic signed [15:0] expected_samples [$];
  logic signed [15:0] oldest_sample;

  int error_count    = 0;
  int cycle_count    = 0;
  int hold_budget    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Directed stimulus. Typed results cover reset defaults, clip extremes and the
  // tiny-threshold cases; feedback rows go through the predictor.
  stim_row_t directed_rows [NUM_ROWS] = '{
    // Reset settings: full-scale threshold, delay far past anything written.
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd0, 1'b1, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd32767, 1'b1, 16'sd32767},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd32768, 1'b1, -16'sd32768},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd1, 1'b1, 16'sd2},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd1, 1'b1, -16'sd2},
    // Zero threshold: the divider result is discarded, the clipped term vanishes.
    '{ROW_WRITE, REG_CLIP_THRESHOLD, 15'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd12345, 1'b1, 16'sd12345},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd32768, 1'b1, -16'sd32768},
    // Thresholds below range: clipped inputs normalize to full scale.
    '{ROW_WRITE, REG_CLIP_THRESHOLD, 15'd1, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd5, 1'b1, 16'sd32767},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd5, 1'b1, -16'sd32768},
    '{ROW_WRITE, REG_CLIP_THRESHOLD, 15'd2, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd1, 1'b1, 16'sd16385},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd2, 1'b1, -16'sd32768},
    // Unity feedback at the shortest delay, with store saturation.
    '{ROW_WRITE, REG_CLIP_THRESHOLD, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_DELAY_SAMPLES, 15'd1, 16'sd0, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_FEEDBACK_GAIN, 15'd16384, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd1000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd32767, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd32767, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd32768, 1'b0, 16'sd0},
    // Gain above range, then no feedback at all.
    '{ROW_WRITE, REG_FEEDBACK_GAIN, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd20000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd20000, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd30000, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_FEEDBACK_GAIN, 15'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd100, 1'b0, 16'sd0},
    // Zero delay reads the slot about to be overwritten; then the longest delay.
    '{ROW_WRITE, REG_DELAY_SAMPLES, 15'd0, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd7, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd7, 1'b0, 16'sd0},
    '{ROW_WRITE, REG_DELAY_SAMPLES, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd4, 1'b0, 16'sd0},
    // Write to a nonexistent register must leave the settings alone.
    '{ROW_WRITE, REG_UNUSED, 15'd32767, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd9, 1'b0, 16'sd0},
    // Lowest in-range threshold.
    '{ROW_WRITE, REG_CLIP_THRESHOLD, 15'd3, 16'sd0, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, 16'sd3, 1'b0, 16'sd0},
    '{ROW_SAMPLE, 2'd0, 15'd0, -16'sd32768, 1'b0, 16'sd0}
  };

  clip_normalize_feedback_delay_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_sample(out_sample),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Saturate to the Q1.15 range.
  function automatic longint clamp_q15(input longint v);
    if (v > 32767) begin
      return 32767;
    end else if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // Compute the output sample for one accepted input and advance the echo line.
  function automatic logic signed [15:0] predict_sample(input logic signed [15:0] x);
    longint      xs;
    longint      th;
    longint      clipped;
    longint      norm;
    longint      fbk;
    longint      stored;
    int unsigned rd_pos;
    xs = x;
    th = thr_cfg;
    // Hard clip to +/- threshold, then scale by 32768 / threshold, truncating to zero.
    if (xs >= 0) begin
      clipped = (xs > th) ? th : xs;
    end else begin
      clipped = (xs < -th) ? -th : xs;
    end
    norm = (th == 0) ? 0 : clamp_q15((clipped * 32768) / th);
    // Tap delay_cfg entries back; the read precedes this item's write.
    rd_pos = (echo_wr + DELAY_DEPTH - (delay_cfg % DELAY_DEPTH)) % DELAY_DEPTH;
    // Q2.14 gain, rounded half up via a floor shift.
    fbk = (longint'(echo_line[rd_pos]) * longint'(gain_cfg) + 64'sd8192) >>> 14;
    stored = clamp_q15(xs + fbk);
    echo_line[echo_wr] = stored[15:0];
    echo_wr = (echo_wr + 1) % DELAY_DEPTH;
    return 16'(clamp_q15(norm + stored));
  endfunction

  // Offer one register write and hold it until taken; cfg_valid stays high so
  // writes can run back to back, and the caller drops it afterwards.
  task automatic write_register(input logic [1:0] idx, input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CLIP_THRESHOLD: thr_cfg = v;
      REG_DELAY_SAMPLES:  delay_cfg = v;
      REG_FEEDBACK_GAIN:  gain_cfg = v;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [14:0] thr, input logic [14:0] dly,
                           input logic [14:0] gain);
    write_register(REG_CLIP_THRESHOLD, thr);
    write_register(REG_DELAY_SAMPLES, dly);
    write_register(REG_FEEDBACK_GAIN, gain);
    cfg_valid <= 1'b0;
  endtask

  // Idle at random, then present one item and hold it until the block takes it.
  // This task drops valid only when an idle cycle is drawn; wait_for_results also drops it.
  task automatic send_sample(input logic signed [15:0] s, input logic typed,
                             input logic signed [15:0] want);
    logic signed [15:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    predicted = predict_sample(s);
    expected_samples.push_back(typed ? want : predicted);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  // Receiver: honor a requested long hold first, otherwise stall at the
  // current random rate.
  always @(posedge clk) begin
    if (hold_budget > 0) begin
      out_stall <= 1'b1;
      hold_budget--;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: every accepted item must match the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        error_count++;
        if (error_count <= MAX_SHOWN) begin
          $display("unexpected result item: out_sample=%0d", out_sample);
        end
      end else begin
        oldest_sample = expected_samples.pop_front();
        if (out_sample !== oldest_sample) begin
          error_count++;
          if (error_count <= MAX_SHOWN) begin
            $display("out_sample mismatch: expected %0d, got %0d", oldest_sample, out_sample);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic signed [15:0] sample_v;
    int                 ph;
    int                 k;

    // Predictor starts from the reset state: empty echo line, default registers.
    foreach (echo_line[i]) echo_line[i] = '0;
    echo_wr   = 0;
    thr_cfg   = CLIP_THRESHOLD_RST;
    delay_cfg = DELAY_SAMPLES_RST;
    gain_cfg  = FEEDBACK_GAIN_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, no idling on either side. Register rows wait for the
    // block to drain first.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (expected_samples.size() != 0) begin
          wait_for_results();
        end
        write_register(directed_rows[r].idx, directed_rows[r].value);
      end else begin
        cfg_valid <= 1'b0;
        send_sample(directed_rows[r].sample, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    // Random phases: sender-light/receiver-heavy idling, then the reverse,
    // then none. Settings change only with the block drained.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_for_results();
      case (ph / 2)
        0: begin
          send_idle_pct  = 36;
          recv_stall_pct = 80;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 36;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      case (ph)
        0: configure(15'($urandom_range(32767, 3)), 15'($urandom_range(64, 1)),
                     15'($urandom_range(18022, 0)));
        1: configure(15'd3, 15'd1, 15'd18022);
        2: configure(15'd32767, 15'($urandom_range(300, 1)),
                     15'($urandom_range(32767, 0)));
        3: begin
          write_register(REG_UNUSED, 15'($urandom_range(32767, 0)));
          configure(15'($urandom_range(32767, 0)), 15'($urandom_range(32767, 0)),
                    15'($urandom_range(32767, 0)));
        end
        4: configure(15'($urandom_range(32767, 3)), 15'd2, 15'd16384);
        default: configure(15'($urandom_range(32767, 3)), 15'($urandom_range(120, 1)),
                           15'd0);
      endcase

      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Hold the output off long enough to back the block up into its input.
        if (ph == 0 && k == 30) begin
          hold_budget = LONG_HOLD;
        end
        // Pause the sender mid-stream until the block has fully drained.
        if (ph == 2 && k == 50) begin
          wait_for_results();
        end
        // Mix full-scale corners, the clip edge, wide random and small values.
        case ($urandom_range(5))
          0: begin
            case ($urandom_range(2))
              0:       sample_v = 16'sh7fff;
              1:       sample_v = 16'sh8000;
              default: sample_v = '0;
            endcase
          end
          1: begin
            sample_v = {1'b0, thr_cfg};
            if ($urandom_range(1) != 0) begin
              sample_v = -sample_v;
            end
          end
          2, 3:    sample_v = 16'($urandom);
          default: sample_v = 16'(int'($urandom_range(1023)) - 512);
        endcase
        send_sample(sample_v, 1'b0, '0);
      end
    end

    // Drain every owed result, then let the pipeline settle.
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
